/* hw/rtl/pbta_pkg.sv */
// ----------------------------------------------------------------------------
// pbta_pkg
// Shared widths, codes and defaults for the paged block table allocator.
// ----------------------------------------------------------------------------
package pbta_pkg;

	// default pool size
	localparam int NUM_BLOCKS_DEF = 64;

	// field widths
	localparam int OP_W   = 2;
	localparam int IDX_W  = 14;
	localparam int ST_W   = 2;
	localparam int PB_W   = 6;
	localparam int OFF_W  = 8;
	localparam int ROW_W  = 14;
	localparam int LEN_W  = 15;
	localparam int FB_W   = 7;
	localparam int LG_W   = 4;

	// block size limits
	localparam logic [LG_W-1:0]  LG_RESET = 4'd4;
	localparam logic [LG_W-1:0]  MAX_LOG2 = 4'd8;
	localparam logic [LEN_W-1:0] MAX_LEN  = 15'd16384;

	// operation codes
	localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] STAT_OK        = 2'd0;
	localparam logic [ST_W-1:0] STAT_NO_BLOCKS = 2'd1;
	localparam logic [ST_W-1:0] STAT_RANGE     = 2'd2;

endpackage

/* hw/rtl/pbta_if.sv */
// ----------------------------------------------------------------------------
// pbta request / response channels
// Valid/ready channels carrying one request word and one response word.
// ----------------------------------------------------------------------------
interface pbta_req_if;
	logic                        valid;
	logic                        ready;
	logic [pbta_pkg::OP_W-1:0]   op;
	logic [pbta_pkg::IDX_W-1:0]  token_index;

	modport source (output valid, output op, output token_index, input ready);
	modport sink (input valid, input op, input token_index, output ready);
endinterface

interface pbta_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [pbta_pkg::ST_W-1:0]   status;
	logic [pbta_pkg::PB_W-1:0]   physical_block;
	logic [pbta_pkg::OFF_W-1:0]  offset;
	logic [pbta_pkg::ROW_W-1:0]  row;
	logic [pbta_pkg::LEN_W-1:0]  length;
	logic [pbta_pkg::FB_W-1:0]   free_blocks;

	modport source (output valid, output status, output physical_block, output offset,
		output row, output length, output free_blocks, input ready);
	modport sink (input valid, input status, input physical_block, input offset,
		input row, input length, input free_blocks, output ready);
endinterface

/* hw/rtl/pbta_ram.sv */
// ----------------------------------------------------------------------------
// pbta_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pbta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/paged_block_table_allocator_core.sv */
// ----------------------------------------------------------------------------
// paged_block_table_allocator_core
// Paged token cache manager: LIFO free list of physical blocks and a logical
// block table, both held in synchronous RAMs.
//
//   channel   dir   handshake          word
//   req       in    valid/ready        op, token_index
//   rsp       out   valid/ready        status, physical_block, offset, row,
//                                      length, free_blocks
//   cfg       in    cfg_wr_en          cfg_wr_data (block_size_log2)
//
// Append and lookup, when no block is popped, go through one block table
// read, then the result register.
// An append that pops adds a table read after the pops; a block that came
// back through clear also needs a free-list RAM read for the next head.
// Clear does a table read and a free-list push per block, overlapped.
// Reset needs no clearing pass: never-used blocks are tracked by a high-water
// mark instead of initializing the free-list RAM.
// A new request is taken while the previous result waits in the rsp register.
// ----------------------------------------------------------------------------
module paged_block_table_allocator_core #(
	parameter int NUM_BLOCKS = pbta_pkg::NUM_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [pbta_pkg::LG_W-1:0]   cfg_wr_data,
	pbta_req_if.sink                    req,
	pbta_rsp_if.source                  rsp
);

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int PW = $clog2(NUM_BLOCKS + 1);
	localparam int LEN_W = pbta_pkg::LEN_W;
	localparam logic [PW-1:0] END_MARK = PW'(NUM_BLOCKS);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_POP  = 5'b00010,
		S_POPW = 5'b00100,
		S_RESP = 5'b01000,
		S_CLR  = 5'b10000
	} state_t;

	state_t                      state_q;
	logic [pbta_pkg::LG_W-1:0]   lg_q;
	logic [LEN_W-1:0]            len_q;
	logic [PW-1:0]               tcount_q;
	logic [PW-1:0]               free_q;
	logic [PW-1:0]               head_q;
	logic [PW-1:0]               fresh_q;
	logic [PW-1:0]               clr_idx_q;
	logic                        clr_pend_s1;
	logic                        rsp_valid_q;

	// per-item payload
	logic [LEN_W-1:0]            logical_q;
	logic [pbta_pkg::OFF_W-1:0]  off_q;
	logic [pbta_pkg::ST_W-1:0]   status_q;
	logic                        hit_q;
	logic                        adv_q;

	// response register payload
	logic [pbta_pkg::ST_W-1:0]   rsp_status_q;
	logic [pbta_pkg::PB_W-1:0]   rsp_pb_q;
	logic [pbta_pkg::OFF_W-1:0]  rsp_off_q;
	logic [pbta_pkg::ROW_W-1:0]  rsp_row_q;
	logic [LEN_W-1:0]            rsp_len_q;
	logic [pbta_pkg::FB_W-1:0]   rsp_free_q;

	// ram ports
	logic          bt_we, bt_re;
	logic [BW-1:0] bt_waddr, bt_raddr, bt_wdata, bt_rdata;
	logic          fn_we, fn_re;
	logic [BW-1:0] fn_waddr, fn_raddr;
	logic [PW-1:0] fn_wdata, fn_rdata;

	logic [pbta_pkg::LG_W-1:0]   lg_eff;
	logic                        accept;
	logic [LEN_W-1:0]            req_base;
	logic [LEN_W-1:0]            req_logical;
	logic [pbta_pkg::OFF_W-1:0]  req_off;
	logic                        pop_need, pop_fail, pop_go, pop_fresh;
	logic                        clr_rd, clr_done, out_free;
	logic [BW-1:0]               res_pb;
	logic [pbta_pkg::ROW_W-1:0]  res_row;

	// effective block size
	assign lg_eff = (lg_q > pbta_pkg::MAX_LOG2) ? pbta_pkg::MAX_LOG2 : lg_q;

	// request decode
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign req_base  = (req.op == pbta_pkg::OP_APPEND) ? len_q : LEN_W'(req.token_index);
	assign req_logical = req_base >> lg_eff;
	assign req_off = pbta_pkg::OFF_W'(req_base & ((LEN_W'(1) << lg_eff) - LEN_W'(1)));

	// pop loop conditions
	assign pop_need  = LEN_W'(tcount_q) <= logical_q;
	assign pop_fail  = pop_need && (tcount_q == END_MARK || head_q == END_MARK);
	assign pop_go    = (state_q == S_POP) && pop_need && !pop_fail;
	assign pop_fresh = (head_q == fresh_q);

	// clear walk
	assign clr_rd   = (state_q == S_CLR) && (clr_idx_q != tcount_q);
	assign clr_done = (state_q == S_CLR) && !clr_rd && !clr_pend_s1;

	assign out_free = !rsp_valid_q || rsp.ready;

	// block table port control
	always_comb begin
		bt_we    = pop_go;
		bt_waddr = BW'(tcount_q);
		bt_wdata = BW'(head_q);
		bt_re    = 1'b0;
		bt_raddr = BW'(clr_idx_q);
		if (accept) begin
			bt_re    = 1'b1;
			bt_raddr = BW'(req_logical);
		end else if (state_q == S_POP && !pop_need) begin
			bt_re    = 1'b1;
			bt_raddr = BW'(logical_q);
		end else if (clr_rd) begin
			bt_re    = 1'b1;
		end
	end

	// free list port control: pop reads the next head, clear pushes
	always_comb begin
		fn_re    = pop_go && !pop_fresh;
		fn_raddr = BW'(head_q);
		fn_we    = (state_q == S_CLR) && clr_pend_s1;
		fn_waddr = bt_rdata;
		fn_wdata = head_q;
	end

	// result fields
	assign res_pb  = hit_q ? bt_rdata : '0;
	assign res_row = hit_q ? pbta_pkg::ROW_W'((pbta_pkg::ROW_W'(bt_rdata) << lg_eff)
		+ pbta_pkg::ROW_W'(off_q)) : '0;

	pbta_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS)) u_block_table (
		.clk   (clk),
		.we    (bt_we),
		.waddr (bt_waddr),
		.wdata (bt_wdata),
		.re    (bt_re),
		.raddr (bt_raddr),
		.rdata (bt_rdata)
	);

	pbta_ram #(.WIDTH(PW), .DEPTH(NUM_BLOCKS)) u_free_next (
		.clk   (clk),
		.we    (fn_we),
		.waddr (fn_waddr),
		.wdata (fn_wdata),
		.re    (fn_re),
		.raddr (fn_raddr),
		.rdata (fn_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			lg_q        <= pbta_pkg::LG_RESET;
			len_q       <= '0;
			tcount_q    <= '0;
			free_q      <= END_MARK;
			head_q      <= '0;
			fresh_q     <= '0;
			clr_idx_q   <= '0;
			clr_pend_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				lg_q <= cfg_wr_data;
			end
			// response valid: set when the word is loaded, cleared when taken
			if (state_q == S_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.op)
							pbta_pkg::OP_APPEND: begin
								if (!len_q[LEN_W-1] && LEN_W'(tcount_q) <= req_logical) begin
									state_q <= S_POP;
								end else begin
									state_q <= S_RESP;
								end
							end
							pbta_pkg::OP_CLEAR: begin
								clr_idx_q   <= '0;
								clr_pend_s1 <= 1'b0;
								state_q     <= S_CLR;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_POP: begin
					if (!pop_need || pop_fail) begin
						state_q <= S_RESP;
					end else begin
						tcount_q <= tcount_q + PW'(1);
						free_q   <= free_q - PW'(1);
						if (pop_fresh) begin
							// first use of this block: its successor is the next one
							head_q  <= head_q + PW'(1);
							fresh_q <= fresh_q + PW'(1);
						end else begin
							state_q <= S_POPW;
						end
					end
				end
				S_POPW: begin
					head_q  <= fn_rdata;
					state_q <= S_POP;
				end
				S_CLR: begin
					if (clr_rd) begin
						clr_idx_q <= clr_idx_q + PW'(1);
					end
					clr_pend_s1 <= clr_rd;
					if (clr_pend_s1) begin
						head_q <= PW'(bt_rdata);
						free_q <= free_q + PW'(1);
					end
					if (clr_done) begin
						tcount_q <= '0;
						len_q    <= '0;
						state_q  <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						if (adv_q) begin
							len_q <= len_q + LEN_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and response word
	always_ff @(posedge clk) begin
		if (accept) begin
			logical_q <= req_logical;
			off_q     <= req_off;
			case (req.op)
				pbta_pkg::OP_APPEND: begin
					status_q <= len_q[LEN_W-1] ? pbta_pkg::STAT_NO_BLOCKS : pbta_pkg::STAT_OK;
					hit_q    <= !len_q[LEN_W-1];
					adv_q    <= !len_q[LEN_W-1];
				end
				pbta_pkg::OP_LOOKUP: begin
					if (LEN_W'(req.token_index) >= len_q || req_logical >= LEN_W'(tcount_q)) begin
						status_q <= pbta_pkg::STAT_RANGE;
						hit_q    <= 1'b0;
					end else begin
						status_q <= pbta_pkg::STAT_OK;
						hit_q    <= 1'b1;
					end
					adv_q <= 1'b0;
				end
				default: begin
					status_q <= pbta_pkg::STAT_OK;
					hit_q    <= 1'b0;
					adv_q    <= 1'b0;
				end
			endcase
		end else if (state_q == S_POP && pop_fail) begin
			status_q <= pbta_pkg::STAT_NO_BLOCKS;
			hit_q    <= 1'b0;
			adv_q    <= 1'b0;
		end
		if (state_q == S_RESP && out_free) begin
			rsp_status_q <= status_q;
			rsp_pb_q     <= pbta_pkg::PB_W'(res_pb);
			rsp_off_q    <= hit_q ? off_q : '0;
			rsp_row_q    <= res_row;
			rsp_len_q    <= adv_q ? len_q + LEN_W'(1) : len_q;
			rsp_free_q   <= pbta_pkg::FB_W'(free_q);
		end
	end

	// response channel
	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.physical_block = rsp_pb_q;
	assign rsp.offset         = rsp_off_q;
	assign rsp.row            = rsp_row_q;
	assign rsp.length         = rsp_len_q;
	assign rsp.free_blocks    = rsp_free_q;

	// every block is either on the free list or in the table, outside a clear walk
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR)
		|| ((PW+1)'(free_q) + (PW+1)'(tcount_q) == (PW+1)'(NUM_BLOCKS)))
		else $error("block count lost");

	// empty list and end-of-list head agree once the head is reloaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POPW) || ((free_q == '0) == (head_q == END_MARK)))
		else $error("free count and head disagree");

	// head is a recycled block or the next never-used one
	assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= fresh_q)
		else $error("head beyond high-water mark");

	// length stays within the pool row range
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= pbta_pkg::MAX_LEN)
		else $error("length overflow");

endmodule
